@@ sv/tli_pkg.sv @@
// Shared types and constants of the table linear interpolator.
// Used by tli_alu, tli_table and table_linear_interpolator; no dependencies.
`default_nettype none

package tli_pkg;

  localparam int unsigned CNT_W     = 9;   // point_count register
  localparam int unsigned IDX_W     = 8;   // entry_index field
  localparam int unsigned DATA_W    = 32;  // Q16.16 words
  localparam int unsigned ALU_W     = 36;  // shared add/sub unit
  localparam int unsigned MAG_W     = 33;  // |dy|, dx and segment width
  localparam int unsigned PROD_W    = 66;  // exact product / quotient register
  localparam int unsigned STEP_W    = 7;   // iteration counter
  localparam int unsigned MUL_STEPS = 33;
  localparam int unsigned DIV_STEPS = 66;

  localparam logic [CNT_W-1:0] COUNT_RESET = 9'd2;

  // beat kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // operand set-up steps after a segment is found
  localparam logic [1:0] PREP_DY  = 2'd0;
  localparam logic [1:0] PREP_MAG = 2'd1;
  localparam logic [1:0] PREP_DX  = 2'd2;
  localparam logic [1:0] PREP_W   = 2'd3;

  typedef struct packed {
    logic                     mode;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_scale;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] query_x;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     out_of_range;
  } out_t;

  typedef struct packed {
    logic [DATA_W-1:0] scale;
    logic [DATA_W-1:0] value;
  } tbl_entry_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  localparam out_t OOR_RES = '{result_value: '0, out_of_range: 1'b1};

endpackage

`default_nettype wire

@@ sv/tli_alu.sv @@
// Shared 36-bit adder/subtractor of the interpolator sequencer.
// Depends on tli_pkg.
`default_nettype none

module tli_alu (
  input  tli_pkg::alu_req_t         req_i,
  output logic [tli_pkg::ALU_W-1:0] sum_o
);
  import tli_pkg::*;

  logic [ALU_W-1:0] b_eff;

  // two's complement subtract: a + ~b + 1
  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign sum_o = req_i.a + b_eff + ALU_W'(req_i.sub);

endmodule

`default_nettype wire

@@ sv/tli_table.sv @@
// Breakpoint table: one write port, one registered read port.
// Depends on tli_pkg.
`default_nettype none

module tli_table #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  tli_pkg::tbl_entry_t        wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output tli_pkg::tbl_entry_t        rdata_o
);
  import tli_pkg::*;

  tbl_entry_t mem [DEPTH];
  tbl_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/table_linear_interpolator.sv @@
// Piecewise linear interpolation over a table of Q16.16 breakpoints. A write beat
// (mode 0) stores one scale/value pair without stalling the input. A query beat
// (mode 1) scans from index 0 for the first breakpoint whose scale is at least x,
// up to index point_count - 1 (at most 255 for a full 256-entry table); an
// out-of-range answer skips the multiply and divide, and a count below 2 gives
// one without a scan. The scan does one table read per scan cycle, and the single
// 36-bit add/sub unit carries 33 shift-add multiply steps and 66 restoring
// divide steps. in_stall_o is high while a query is in flight; a finished result
// waits in the output register without blocking the next beat.
// Depends on tli_pkg, tli_alu and tli_table.
`default_nettype none

module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tli_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  tli_pkg::in_t               in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output tli_pkg::out_t              out_o
);
  import tli_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_PREP = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  function automatic logic [ALU_W-1:0] sext(input logic [DATA_W-1:0] v);
    return {{(ALU_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  state_e              state_q, state_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [IW-1:0]       last_q, last_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]    pc_q;
  logic                out_valid_q;
  out_t                out_q;
  logic                load_out;

  logic [DATA_W-1:0]   x_q, x_d, x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic                neg_q, neg_d;
  logic [MAG_W-1:0]    mag_q, mag_d, d_q, d_d, w_q, w_d, rem_q, rem_d;
  logic [PROD_W-1:0]   p_q, p_d;
  out_t                res_q, res_d;

  logic                in_accept;
  logic [CW-1:0]       pc_ext, depth_c, eff_cnt;
  logic                few_points;
  logic                tbl_we;
  tbl_entry_t          tbl_wdata, tbl_rdata;
  alu_req_t            alu_req;
  logic [ALU_W-1:0]    alu_y;
  logic                ge;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign pc_ext     = CW'(pc_q);
  assign depth_c    = CW'(TABLE_DEPTH);
  assign eff_cnt    = (pc_ext > depth_c) ? depth_c : pc_ext;
  assign few_points = (eff_cnt < CW'(2));

  assign tbl_we    = in_accept && (in_i.mode == MODE_WRITE) &&
                     (CW'(in_i.entry_index) < depth_c);
  assign tbl_wdata = '{scale: in_i.entry_scale, value: in_i.entry_value};

  tli_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (IW'(CW'(in_i.entry_index))),
    .wdata_i (tbl_wdata),
    .raddr_i (idx_d),
    .rdata_o (tbl_rdata)
  );

  tli_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_y)
  );

  assign ge = !alu_y[ALU_W-1];

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    x_d      = x_q;
    x0_d     = x0_q;
    y0_d     = y0_q;
    x1_d     = x1_q;
    y1_d     = y1_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    d_d      = d_q;
    w_d      = w_q;
    rem_d    = rem_q;
    p_d      = p_q;
    res_d    = res_q;
    load_out = 1'b0;
    alu_req  = '{sub: 1'b1, a: '0, b: '0};

    case (state_q)
      S_IDLE: begin
        if (in_accept && (in_i.mode == MODE_QUERY)) begin
          x_d    = in_i.query_x;
          idx_d  = '0;
          last_d = IW'(eff_cnt - CW'(1));
          if (few_points) begin
            res_d   = OOR_RES;
            state_d = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read data belongs to idx_q; hit when scale >= x
        alu_req = '{sub: 1'b1, a: sext(tbl_rdata.scale), b: sext(x_q)};
        if (ge) begin
          if (idx_q == '0) begin
            res_d   = OOR_RES;
            state_d = S_OUT;
          end else begin
            x1_d    = tbl_rdata.scale;
            y1_d    = tbl_rdata.value;
            cnt_d   = '0;
            state_d = S_PREP;
          end
        end else begin
          x0_d = tbl_rdata.scale;
          y0_d = tbl_rdata.value;
          if (idx_q == last_q) begin
            res_d   = OOR_RES;
            state_d = S_OUT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_PREP: begin
        cnt_d = cnt_q + 1'b1;
        case (cnt_q[1:0])
          PREP_DY: begin
            alu_req = '{sub: 1'b1, a: sext(y1_q), b: sext(y0_q)};
            neg_d   = alu_y[ALU_W-1];
          end
          PREP_MAG: begin
            alu_req = '{sub: 1'b1, a: sext(neg_q ? y0_q : y1_q),
                        b: sext(neg_q ? y1_q : y0_q)};
            mag_d   = alu_y[MAG_W-1:0];
          end
          PREP_DX: begin
            alu_req = '{sub: 1'b1, a: sext(x_q), b: sext(x0_q)};
            d_d     = alu_y[MAG_W-1:0];
          end
          PREP_W: begin
            alu_req = '{sub: 1'b1, a: sext(x1_q), b: sext(x0_q)};
            w_d     = alu_y[MAG_W-1:0];
            cnt_d   = '0;
            if (alu_y[ALU_W-1] || (alu_y == '0)) begin
              res_d   = OOR_RES;
              state_d = S_OUT;
            end else begin
              p_d     = {{(PROD_W-MAG_W){1'b0}}, d_q};
              state_d = S_MUL;
            end
          end
          default: ;
        endcase
      end
      S_MUL: begin
        // right-shifting shift-add: high half accumulates |dy|
        alu_req = '{sub: 1'b0,
                    a: {{(ALU_W-MAG_W){1'b0}}, p_q[PROD_W-1:MAG_W]},
                    b: p_q[0] ? {{(ALU_W-MAG_W){1'b0}}, mag_q} : '0};
        p_d     = {alu_y[MAG_W:0], p_q[MAG_W-1:1]};
        if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIV: begin
        // restoring step; quotient bits shift in behind the dividend
        alu_req = '{sub: 1'b1,
                    a: {{(ALU_W-MAG_W-1){1'b0}}, rem_q, p_q[PROD_W-1]},
                    b: {{(ALU_W-MAG_W){1'b0}}, w_q}};
        rem_d   = ge ? alu_y[MAG_W-1:0] : {rem_q[MAG_W-2:0], p_q[PROD_W-1]};
        p_d     = {p_q[PROD_W-2:0], ge};
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_SUM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SUM: begin
        alu_req = '{sub: neg_q, a: sext(y0_q),
                    b: {{(ALU_W-MAG_W-1){1'b0}}, p_q[MAG_W:0]}};
        res_d.out_of_range = 1'b0;
        if ((alu_y[ALU_W-1:DATA_W-1] == '0) || (alu_y[ALU_W-1:DATA_W-1] == '1)) begin
          res_d.result_value = alu_y[DATA_W-1:0];
        end else if (alu_y[ALU_W-1]) begin
          res_d.result_value = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
          res_d.result_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      last_q      <= '0;
      cnt_q       <= '0;
      pc_q        <= COUNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    x0_q  <= x0_d;
    y0_q  <= y0_d;
    x1_q  <= x1_d;
    y1_q  <= y1_d;
    neg_q <= neg_d;
    mag_q <= mag_d;
    d_q   <= d_d;
    w_q   <= w_d;
    rem_q <= rem_d;
    p_q   <= p_d;
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_i.mode == MODE_QUERY) |=> (state_q == S_SCAN || state_q == S_OUT))
    else $error("query beat did not start a scan");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> idx_q <= last_q)
    else $error("scan index past last breakpoint");

  a_rem_below_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < w_q)
    else $error("divider remainder not below segment width");

  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SUM |-> p_q[PROD_W-1:MAG_W+1] == '0)
    else $error("quotient exceeds value step");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.out_of_range |-> out_o.result_value == '0)
    else $error("out-of-range result carries a value");

endmodule

`default_nettype wire
